// ----- src/wbcs_pkg.sv -----
// Shared types, widths and constants for the white blob centroid steering block.
// No dependencies; imported by every module under src.
package wbcs_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_PIXELS = 4194304;

  localparam int WIDTH_W = 13;
  localparam int COL_W   = 12;
  localparam int HALF_W  = 12;
  localparam int CNT_W   = 23;
  localparam int SUM_W   = 34;
  localparam int DEN_W   = 34;
  localparam int NUM_W   = 49;
  localparam int Q_W     = 16;
  localparam int STEP_W  = 4;
  localparam int PIX_W   = 8;
  localparam int GAIN_W  = 8;
  localparam int SPEED_W = 8;
  localparam int TURN_W  = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [PIX_W-1:0] WHITE_LEVEL = 8'd255;
  localparam int GAIN_SHIFT = 6;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 8'd80;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 8'd128;

  localparam logic [Q_W-1:0] Q_POS_MAX = 16'd32767;
  localparam logic [Q_W-1:0] Q_NEG_MAX = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH     = 2'd0,
    REG_TURN_GAIN     = 2'd1,
    REG_FORWARD_SPEED = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic diff;
    logic mag;
    logic chk;
    logic step;
    logic out_load;
  } wbcs_cmd_t;

  function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] r;
    r = w;
    if (w < WIDTH_W'(2)) r = WIDTH_W'(2);
    else if (w > WIDTH_W'(MAX_WIDTH)) r = WIDTH_W'(MAX_WIDTH);
    return r;
  endfunction

endpackage

// ----- src/wbcs_accum.sv -----
// Pixel accumulator: column tracking, white pixel sum and count per frame.
// Depends on wbcs_pkg.
module wbcs_accum import wbcs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [PIX_W-1:0]   red,
  input  logic [PIX_W-1:0]   green,
  input  logic [PIX_W-1:0]   blue,
  input  logic               eof,
  input  logic [WIDTH_W-1:0] row_width,
  output logic [SUM_W-1:0]   frame_sum,
  output logic [CNT_W-1:0]   frame_cnt
);

  logic [COL_W-1:0]   column;
  logic [CNT_W-1:0]   white_count;
  logic [SUM_W-1:0]   column_sum;

  logic [WIDTH_W-1:0] w;
  logic [WIDTH_W-1:0] col_eff;
  logic [WIDTH_W-1:0] col_inc;
  logic [COL_W-1:0]   column_next;
  logic               hit;

  always_comb begin
    w       = eff_width(row_width);
    col_eff = ({1'b0, column} >= w) ? '0 : {1'b0, column};
    col_inc = col_eff + WIDTH_W'(1);
    column_next = (col_inc >= w) ? '0 : col_inc[COL_W-1:0];
    hit = (red == WHITE_LEVEL) && (green == WHITE_LEVEL) && (blue == WHITE_LEVEL) &&
          (white_count < CNT_W'(MAX_PIXELS));
    frame_sum = hit ? column_sum + SUM_W'(col_eff) : column_sum;
    frame_cnt = hit ? white_count + CNT_W'(1) : white_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      white_count <= '0;
      column_sum  <= '0;
    end else if (accept) begin
      if (eof) begin
        column      <= '0;
        white_count <= '0;
        column_sum  <= '0;
      end else begin
        column      <= column_next;
        white_count <= frame_cnt;
        column_sum  <= frame_sum;
      end
    end
  end

  a_cnt_limit: assert property (@(posedge clk) disable iff (rst)
    white_count <= CNT_W'(MAX_PIXELS))
    else $error("white count above limit");

  a_eof_clear: assert property (@(posedge clk) disable iff (rst)
    accept && eof |=> column == '0 && white_count == '0 && column_sum == '0)
    else $error("accumulators not cleared at frame end");

endmodule

// ----- src/wbcs_ctrl.sv -----
// Frame-end controller: sequences the multiply, divide and output load steps.
// Depends on wbcs_pkg.
module wbcs_ctrl import wbcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      m_tready,
  output logic      m_tvalid,
  output logic      busy,
  output wbcs_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIFF,
    S_MAG,
    S_CHK,
    S_DIV,
    S_DONE
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step_cnt;
  logic              out_free;

  assign out_free = !m_tvalid || m_tready;
  assign busy     = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && start;
    cmd.mul      = (state == S_MUL);
    cmd.diff     = (state == S_DIFF);
    cmd.mag      = (state == S_MAG);
    cmd.chk      = (state == S_CHK);
    cmd.step     = (state == S_DIV);
    cmd.out_load = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) state <= S_MUL;
        end
        S_MUL:  state <= S_DIFF;
        S_DIFF: state <= S_MAG;
        S_MAG:  state <= S_CHK;
        S_CHK: begin
          step_cnt <= '0;
          state    <= S_DIV;
        end
        S_DIV: begin
          step_cnt <= step_cnt + STEP_W'(1);
          if (step_cnt == STEP_W'(Q_W - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("frame end taken while busy");

  a_out_set: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid && state == S_IDLE)
    else $error("result not presented after load");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !m_tvalid || m_tready)
    else $error("pending result overwritten");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |=> state == S_DIV && step_cnt == '0)
    else $error("divide did not start cleanly");

endmodule

// ----- src/wbcs_dpath.sv -----
// Frame-end datapath: denominator, signed offset, gain product, restoring
// divider and saturating output register. Depends on wbcs_pkg.
module wbcs_dpath import wbcs_pkg::*; (
  input  logic               clk,
  input  wbcs_cmd_t          cmd,
  input  logic [SUM_W-1:0]   frame_sum,
  input  logic [CNT_W-1:0]   frame_cnt,
  input  logic [WIDTH_W-1:0] row_width,
  input  logic [GAIN_W-1:0]  turn_gain,
  input  logic [SPEED_W-1:0] forward_speed,
  output logic               ball_seen,
  output logic [SPEED_W-1:0] speed_command,
  output logic [TURN_W-1:0]  turn_command
);

  logic               seen;
  logic [CNT_W-1:0]   cnt;
  logic [SUM_W-1:0]   sum;
  logic [HALF_W-1:0]  half;
  logic [DEN_W-1:0]   den;
  logic [DEN_W-1:0]   diff;
  logic               neg;
  logic [NUM_W-1:0]   num;
  logic               sat;
  logic [DEN_W-1:0]   rem;
  logic [Q_W-1:0]     lo;
  logic [Q_W-1:0]     q;

  logic [WIDTH_W-1:0] w_eff;
  logic [DEN_W:0]     trial;
  logic               trial_ge;
  logic [Q_W-1:0]     q_clamp;
  logic [TURN_W-1:0]  turn_val;

  always_comb begin
    w_eff    = eff_width(row_width);
    trial    = {rem, lo[Q_W-1]};
    trial_ge = trial >= {1'b0, den};
    if (neg) q_clamp = (sat || q > Q_NEG_MAX) ? Q_NEG_MAX : q;
    else     q_clamp = (sat || q > Q_POS_MAX) ? Q_POS_MAX : q;
    turn_val = neg ? TURN_W'(16'd0 - q_clamp) : TURN_W'(q_clamp);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seen <= (frame_cnt != '0);
      cnt  <= frame_cnt;
      sum  <= frame_sum;
      half <= w_eff[WIDTH_W-1:1];
    end
    if (cmd.mul) den <= DEN_W'(half) * DEN_W'(cnt);
    if (cmd.diff) begin
      neg  <= sum > den;
      diff <= (sum > den) ? sum - den : den - sum;
    end
    if (cmd.mag) begin
      num <= NUM_W'({turn_gain, GAIN_SHIFT'(0)}) * NUM_W'(diff) + NUM_W'(den >> 1);
    end
    if (cmd.chk) begin
      sat <= {1'b0, num} >= {den, Q_W'(0)};
      rem <= DEN_W'(num[NUM_W-1:Q_W]);
      lo  <= num[Q_W-1:0];
      q   <= '0;
    end
    if (cmd.step) begin
      rem <= trial_ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      lo  <= {lo[Q_W-2:0], 1'b0};
      q   <= {q[Q_W-2:0], trial_ge};
    end
    if (cmd.out_load) begin
      ball_seen     <= seen;
      speed_command <= seen ? forward_speed : '0;
      turn_command  <= seen ? turn_val : '0;
    end
  end

endmodule

// ----- src/white_blob_centroid_steering.sv -----
// White blob centroid steering: one RGB pixel per beat, one drive command per frame.
// After a frame's last beat, S_MUL, S_DIFF, S_MAG, S_CHK, S_DIV and S_DONE compute the
// command. Throughput: one pixel per cycle; the last beat of a frame waits until the
// previous frame's computation (16-step divider) has handed its command to the output.
// Reset (rst, synchronous): registers to 640/80/128, accumulators and result valid
// cleared; output data is not reset.
module white_blob_centroid_steering import wbcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic                  s_tlast,   // end_of_frame
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // speed_command[7:0], turn_command[23:8]
  output logic                  m_tuser,   // ball_seen
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [WIDTH_W-1:0] row_width;
  logic [GAIN_W-1:0]  turn_gain;
  logic [SPEED_W-1:0] forward_speed;

  logic               busy;
  logic               accept;
  logic               start;
  wbcs_cmd_t          cmd;
  logic [SUM_W-1:0]   frame_sum;
  logic [CNT_W-1:0]   frame_cnt;
  logic [SPEED_W-1:0] speed_command;
  logic [TURN_W-1:0]  turn_command;

  assign cfg_ready = 1'b1;
  assign s_tready  = !s_tlast || !busy;
  assign accept    = s_tvalid && s_tready;
  assign start     = accept && s_tlast;
  assign m_tdata   = {turn_command, speed_command};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width     <= WIDTH_RESET;
      turn_gain     <= GAIN_RESET;
      forward_speed <= SPEED_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_WIDTH:     row_width     <= cfg_data[WIDTH_W-1:0];
        REG_TURN_GAIN:     turn_gain     <= cfg_data[GAIN_W-1:0];
        REG_FORWARD_SPEED: forward_speed <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  wbcs_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .red       (s_tdata[7:0]),
    .green     (s_tdata[15:8]),
    .blue      (s_tdata[23:16]),
    .eof       (s_tlast),
    .row_width (row_width),
    .frame_sum (frame_sum),
    .frame_cnt (frame_cnt)
  );

  wbcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .busy     (busy),
    .cmd      (cmd)
  );

  wbcs_dpath u_dpath (
    .clk           (clk),
    .cmd           (cmd),
    .frame_sum     (frame_sum),
    .frame_cnt     (frame_cnt),
    .row_width     (row_width),
    .turn_gain     (turn_gain),
    .forward_speed (forward_speed),
    .ball_seen     (m_tuser),
    .speed_command (speed_command),
    .turn_command  (turn_command)
  );

endmodule

// ----- test/tb_top.sv -----
// Testbench for white_blob_centroid_steering: directed frames, then random frames
// under three sender/receiver idling mixes, with every command checked in order.
// Depends on src/wbcs_pkg.sv and src/white_blob_centroid_steering.sv.
module tb_top;
  import wbcs_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_PIXELS  = 96;
  localparam int TURN_SCALE    = 64;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic               ball_seen;
    logic [SPEED_W-1:0] speed;
    logic [TURN_W-1:0]  turn;
  } drive_cmd_t;

  localparam pixel_t WHITE_PX = 24'hFFFFFF;
  localparam pixel_t BLACK_PX = 24'h000000;

  class steering_scoreboard;
    logic [WIDTH_W-1:0] width_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [SPEED_W-1:0] speed_reg;
    longint unsigned    column;
    longint unsigned    white_count;
    longint unsigned    column_sum;
    drive_cmd_t         pending_cmds[$];
    int                 errors;

    function new();
      width_reg   = WIDTH_RESET;
      gain_reg    = GAIN_RESET;
      speed_reg   = SPEED_RESET;
      column      = 0;
      white_count = 0;
      column_sum  = 0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ROW_WIDTH:     width_reg = data[WIDTH_W-1:0];
        REG_TURN_GAIN:     gain_reg  = data[GAIN_W-1:0];
        REG_FORWARD_SPEED: speed_reg = data[SPEED_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(pixel_t px, logic eof);
      longint unsigned w, half, den, diff, mag, q;
      logic neg;
      drive_cmd_t cmd;
      w = width_reg;
      if (w < 2) w = 2;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (column >= w) column = 0;
      if (px.red == WHITE_LEVEL && px.green == WHITE_LEVEL && px.blue == WHITE_LEVEL &&
          white_count < MAX_PIXELS) begin
        column_sum += column;
        white_count += 1;
      end
      if (column + 1 >= w) column = 0;
      else column += 1;
      if (!eof) return;
      cmd = '0;
      if (white_count > 0) begin
        half = w >> 1;
        den  = half * white_count;
        neg  = (den < column_sum);
        diff = neg ? column_sum - den : den - column_sum;
        mag  = longint'(gain_reg) * TURN_SCALE * diff;
        q    = (mag + den / 2) / den;
        if (neg) begin
          if (q > 32768) q = 32768;
          cmd.turn = TURN_W'(0 - q);
        end else begin
          if (q > 32767) q = 32767;
          cmd.turn = TURN_W'(q);
        end
        cmd.ball_seen = 1'b1;
        cmd.speed     = speed_reg;
      end
      pending_cmds.push_back(cmd);
      column      = 0;
      white_count = 0;
      column_sum  = 0;
    endfunction

    function void check_cmd(drive_cmd_t got);
      drive_cmd_t want;
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected command ball=%0d speed=%0d turn=%0d", $time,
                 got.ball_seen, got.speed, $signed(got.turn));
        errors++;
        return;
      end
      want = pending_cmds.pop_front();
      if (got.ball_seen !== want.ball_seen) begin
        $display("%0t: ball_seen expected %0d actual %0d", $time, want.ball_seen,
                 got.ball_seen);
        errors++;
      end
      if (got.speed !== want.speed) begin
        $display("%0t: speed_command expected %0d actual %0d", $time, want.speed, got.speed);
        errors++;
      end
      if (got.turn !== want.turn) begin
        $display("%0t: turn_command expected %0d actual %0d", $time, $signed(want.turn),
                 $signed(got.turn));
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_cmds.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [23:0]           s_tdata;   // red[7:0], green[15:8], blue[23:16]
  logic                  s_tlast;   // end_of_frame
  logic                  m_tvalid;
  logic                  m_tready;
  logic [23:0]           m_tdata;   // speed_command[7:0], turn_command[23:8]
  logic                  m_tuser;   // ball_seen
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  steering_scoreboard sb;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int          hold_left;
  int          cycle_count;

  white_blob_centroid_steering dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_cmd({m_tuser, m_tdata[7:0], m_tdata[23:8]});
  end

  function automatic pixel_t make_pixel(int unsigned white_pct);
    pixel_t px;
    px = pixel_t'($urandom);
    if ($urandom_range(99) < white_pct) begin
      px = WHITE_PX;
    end else if ($urandom_range(3) == 0) begin
      px = WHITE_PX;
      case ($urandom_range(2))
        0: px.red   = PIX_W'($urandom_range(254));
        1: px.green = PIX_W'($urandom_range(254));
        default: px.blue = PIX_W'($urandom_range(254));
      endcase
    end
    return px;
  endfunction

  task automatic send_pixel(input pixel_t px, input logic eof);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    s_tlast  <= eof;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(px, eof);
    @(negedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after its last beat
  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] width, input logic [CFG_DATA_W-1:0] gain,
                          input logic [CFG_DATA_W-1:0] speed, input bit poke_unused);
    cfg_beat(REG_ROW_WIDTH, width);
    cfg_beat(REG_TURN_GAIN, gain);
    cfg_beat(REG_FORWARD_SPEED, speed);
    if (poke_unused) cfg_beat(REG_NONE, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_width();
    case ($urandom_range(9))
      6: return CFG_DATA_W'($urandom_range(17, MAX_WIDTH));
      7: begin
        case ($urandom_range(5))
          0: return CFG_DATA_W'(0);
          1: return CFG_DATA_W'(1);
          2: return CFG_DATA_W'(2);
          3: return CFG_DATA_W'(MAX_WIDTH);
          4: return CFG_DATA_W'(MAX_WIDTH + 1);
          default: return CFG_DATA_W'(8191);
        endcase
      end
      8: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(2, 16));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_byte_reg();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 16'h00FF : 16'h0000;
    return CFG_DATA_W'($urandom);
  endfunction

  initial begin
    int budget;
    int frame_len;
    int unsigned white_pct;

    sb          = new();
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    m_tready    = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_left   = 0;
    cycle_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: empty frame, lone white pixel, near-white only
    send_pixel(BLACK_PX, 1'b1);
    send_pixel(WHITE_PX, 1'b1);
    send_pixel(24'hFEFFFF, 1'b0);
    send_pixel(24'hFFFEFF, 1'b0);
    send_pixel(24'hFFFFFE, 1'b0);
    send_pixel(BLACK_PX, 1'b1);
    drain();

    // width below range acts as 2, columns wrap every two pixels
    set_regs(16'h0000, 16'h00FF, 16'h00FF, 1'b1);
    send_pixel(WHITE_PX, 1'b0);
    send_pixel(WHITE_PX, 1'b0);
    send_pixel(WHITE_PX, 1'b1);
    drain();

    // width above range clamps; zero gain and speed with a ball present
    set_regs(16'd8191, 16'h0000, 16'h0000, 1'b0);
    send_pixel(WHITE_PX, 1'b0);
    send_pixel(24'h123456, 1'b0);
    send_pixel(WHITE_PX, 1'b1);
    drain();

    // upper data bits are dropped: width 3, gain 7, speed 1
    set_regs(16'hE003, 16'h0A07, 16'hFF01, 1'b0);
    send_pixel(WHITE_PX, 1'b0);
    send_pixel(WHITE_PX, 1'b0);
    send_pixel(WHITE_PX, 1'b1);
    drain();

    // width shrinks mid-frame below the current column
    set_regs(16'd16, 16'd200, 16'd77, 1'b0);
    for (int i = 0; i < 8; i++) send_pixel(make_pixel(50), 1'b0);
    drain();
    cfg_beat(REG_ROW_WIDTH, 16'd4);
    cfg_valid <= 1'b0;
    send_pixel(WHITE_PX, 1'b1);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin tx_idle_pct = 38; rx_idle_pct = 53; end
        1: begin tx_idle_pct = 53; rx_idle_pct = 38; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int sub = 0; sub < 4; sub++) begin
        set_regs(pick_width(), pick_byte_reg(), pick_byte_reg(), $urandom_range(3) == 0);
        if (mode == 2 && sub == 0) hold_left = 400;
        budget = PHASE_PIXELS;
        while (budget > 0) begin
          frame_len = ($urandom_range(4) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
          case ($urandom_range(3))
            0: white_pct = 0;
            1: white_pct = 15;
            2: white_pct = 50;
            default: white_pct = 90;
          endcase
          for (int i = 0; i < frame_len && budget > 0; i++) begin
            send_pixel(make_pixel(white_pct), i == frame_len - 1);
            budget--;
          end
        end
        drain();
      end
    end

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/wbcs_pkg.sv
src/wbcs_accum.sv
src/wbcs_ctrl.sv
src/wbcs_dpath.sv
src/white_blob_centroid_steering.sv
test/tb_top.sv
